// ===== hdl/rle_sprite_pixel_decoder_unit_assert.svh =====
// Assertion macros shared by the sprite decoder RTL.
// Expects clk_i and rst_ni in the including module.
`ifndef RLE_SPRITE_PIXEL_DECODER_UNIT_ASSERT_SVH
`define RLE_SPRITE_PIXEL_DECODER_UNIT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define RSPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define RSPD_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/rspd_pkg.sv =====
// Types, codes and defaults for the run-length sprite decoder.
// No dependencies; used by every module of the block.
package rspd_pkg;

  localparam int unsigned PIXEL_COUNT_DEFAULT = 1024;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
  localparam logic [15:0] RUN_LIMIT_RESET     = 16'd3076;

  // input op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_HEADER     = 3'd0;
  localparam logic [2:0] ERR_BLANK_LONG = 3'd1;
  localparam logic [2:0] ERR_DATA_LONG  = 3'd2;
  localparam logic [2:0] ERR_DATA_SHORT = 3'd3;
  localparam logic [2:0] ERR_INDEX      = 3'd4;

  // configuration register indexes
  localparam logic REG_RUN_LIMIT = 1'b0;

  typedef struct packed {
    logic        op;
    logic [11:0] sprite_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] error_code;
    logic       last;
  } out_item_t;

  // One queue entry: up to two results caused by one input beat.
  // The second one is always a done or a header error.
  typedef struct packed {
    out_item_t first;
    logic      has_second;
    logic      second_err;
  } evt_t;

endpackage

// ===== hdl/rspd_front.sv =====
// Front end: parses the run-length stream; each beat with results becomes a queue entry.
// Depends on rspd_pkg.
module rspd_front
  import rspd_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT = PIXEL_COUNT_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  in_item_t    item_i,
  input  logic [15:0] run_limit_i,
  output logic        ev_valid_o,
  output evt_t        ev_o
);

  `include "rle_sprite_pixel_decoder_unit_assert.svh"

  localparam int unsigned PW = $clog2(PIXEL_COUNT + 1);
  localparam int unsigned SW = ((PW > 16) ? PW : 16) + 1;
  localparam logic [11:0] MIN_RUN_BYTES = 12'd4;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_BLANK_LO = 8'b0000_0010,
    PH_BLANK_HI = 8'b0000_0100,
    PH_DATA_LO = 8'b0000_1000,
    PH_DATA_HI = 8'b0001_0000,
    PH_PIX_R   = 8'b0010_0000,
    PH_PIX_G   = 8'b0100_0000,
    PH_PIX_B   = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    BND_DONE = 2'd0,
    BND_ERR  = 2'd1,
    BND_RUN  = 2'd2
  } bnd_e;

  phase_e        phase_q, phase_d;
  logic [11:0]   br_q, br_d;
  logic [15:0]   run_q, run_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    low_q, low_d;
  logic [7:0]    red_q, red_d;
  logic [7:0]    green_q, green_d;

  logic [11:0]   br_dec;
  logic [15:0]   run_val;
  logic          run_over;
  logic [17:0]   need_bytes;
  logic          data_short;
  logic [SW-1:0] pos_sum;
  logic [PW-1:0] pos_sat;
  logic          run_ends;
  bnd_e          bnd_start, bnd_next;

  function automatic bnd_e boundary(logic [11:0] left);
    bnd_e res;
    if (left == '0) begin
      res = BND_DONE;
    end else if (left < MIN_RUN_BYTES) begin
      res = BND_ERR;
    end else begin
      res = BND_RUN;
    end
    return res;
  endfunction

  function automatic out_item_t status_item(logic [1:0] kind, logic [2:0] code);
    out_item_t res;
    res            = '0;
    res.kind       = kind;
    res.error_code = code;
    res.last       = 1'b1;
    return res;
  endfunction

  assign br_dec     = (br_q != '0) ? br_q - 12'd1 : '0;
  assign run_val    = {item_i.data_byte, low_q};
  assign run_over   = run_val > run_limit_i;
  assign need_bytes = {2'b00, run_val} + {1'b0, run_val, 1'b0};
  assign data_short = {6'b0, br_dec} < need_bytes;
  assign pos_sum    = SW'(pos_q) + SW'(run_val);
  assign pos_sat    = (pos_sum > SW'(PIXEL_COUNT)) ? PW'(PIXEL_COUNT) : PW'(pos_sum);
  assign run_ends   = run_q <= 16'd1;
  assign bnd_start  = boundary(item_i.sprite_length);
  assign bnd_next   = boundary(br_dec);

  always_comb begin
    phase_d    = phase_q;
    br_d       = br_q;
    run_d      = run_q;
    pos_d      = pos_q;
    low_d      = low_q;
    red_d      = red_q;
    green_d    = green_q;
    ev_valid_o = 1'b0;
    ev_o       = '0;

    if (item_i.op == OP_START) begin
      br_d    = item_i.sprite_length;
      run_d   = '0;
      pos_d   = '0;
      low_d   = '0;
      red_d   = '0;
      green_d = '0;
      unique case (bnd_start)
        BND_DONE: begin
          phase_d    = PH_IDLE;
          ev_valid_o = 1'b1;
          ev_o.first = status_item(KIND_DONE, ERR_NONE);
        end
        BND_ERR: begin
          phase_d    = PH_IDLE;
          ev_valid_o = 1'b1;
          ev_o.first = status_item(KIND_ERROR, ERR_HEADER);
        end
        default: phase_d = PH_BLANK_LO;
      endcase
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_BLANK_LO: begin
          low_d   = item_i.data_byte;
          br_d    = br_dec;
          phase_d = PH_BLANK_HI;
        end
        PH_DATA_LO: begin
          low_d   = item_i.data_byte;
          br_d    = br_dec;
          phase_d = PH_DATA_HI;
        end
        PH_BLANK_HI: begin
          br_d = br_dec;
          if (run_over) begin
            phase_d    = PH_IDLE;
            ev_valid_o = 1'b1;
            ev_o.first = status_item(KIND_ERROR, ERR_BLANK_LONG);
          end else begin
            pos_d   = pos_sat;
            phase_d = PH_DATA_LO;
          end
        end
        PH_DATA_HI: begin
          br_d = br_dec;
          if (run_over) begin
            phase_d    = PH_IDLE;
            ev_valid_o = 1'b1;
            ev_o.first = status_item(KIND_ERROR, ERR_DATA_LONG);
          end else if (data_short) begin
            phase_d    = PH_IDLE;
            ev_valid_o = 1'b1;
            ev_o.first = status_item(KIND_ERROR, ERR_DATA_SHORT);
          end else if (run_val == '0) begin
            unique case (bnd_next)
              BND_DONE: begin
                phase_d    = PH_IDLE;
                ev_valid_o = 1'b1;
                ev_o.first = status_item(KIND_DONE, ERR_NONE);
              end
              BND_ERR: begin
                phase_d    = PH_IDLE;
                ev_valid_o = 1'b1;
                ev_o.first = status_item(KIND_ERROR, ERR_HEADER);
              end
              default: phase_d = PH_BLANK_LO;
            endcase
          end else begin
            run_d   = run_val;
            phase_d = PH_PIX_R;
          end
        end
        PH_PIX_R: begin
          red_d   = item_i.data_byte;
          br_d    = br_dec;
          phase_d = PH_PIX_G;
        end
        PH_PIX_G: begin
          green_d = item_i.data_byte;
          br_d    = br_dec;
          phase_d = PH_PIX_B;
        end
        PH_PIX_B: begin
          br_d       = br_dec;
          ev_valid_o = 1'b1;
          if (pos_q >= PW'(PIXEL_COUNT)) begin
            phase_d    = PH_IDLE;
            ev_o.first = status_item(KIND_ERROR, ERR_INDEX);
          end else begin
            ev_o.first.kind        = KIND_PIXEL;
            ev_o.first.pixel_index = 10'(pos_q);
            ev_o.first.red         = red_q;
            ev_o.first.green       = green_q;
            ev_o.first.blue        = item_i.data_byte;
            ev_o.first.error_code  = ERR_NONE;
            ev_o.first.last        = 1'b1;
            pos_d = pos_q + PW'(1);
            run_d = (run_q != '0) ? run_q - 16'd1 : '0;
            if (!run_ends) begin
              phase_d = PH_PIX_R;
            end else begin
              // run finished: a done or header error may ride along
              unique case (bnd_next)
                BND_DONE: begin
                  phase_d          = PH_IDLE;
                  ev_o.first.last  = 1'b0;
                  ev_o.has_second  = 1'b1;
                  ev_o.second_err  = 1'b0;
                end
                BND_ERR: begin
                  phase_d          = PH_IDLE;
                  ev_o.first.last  = 1'b0;
                  ev_o.has_second  = 1'b1;
                  ev_o.second_err  = 1'b1;
                end
                default: phase_d = PH_BLANK_LO;
              endcase
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      br_q    <= '0;
      run_q   <= '0;
      pos_q   <= '0;
      low_q   <= '0;
      red_q   <= '0;
      green_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      br_q    <= br_d;
      run_q   <= run_d;
      pos_q   <= pos_d;
      low_q   <= low_d;
      red_q   <= red_d;
      green_q <= green_d;
    end
  end

  `RSPD_ASSERT(a_error_goes_idle, accept_i && ev_valid_o && ev_o.first.kind == KIND_ERROR |=> phase_q == PH_IDLE, "front not idle after error")

endmodule

// ===== hdl/rspd_queue.sv =====
// Short queue of parsed entries between the front end and the result drain.
// Depends on rspd_pkg.
module rspd_queue
  import rspd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  evt_t push_data_i,
  input  logic pop_i,
  output evt_t head_o,
  output logic empty_o,
  output logic full_o
);

  `include "rle_sprite_pixel_decoder_unit_assert.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  evt_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_pop;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == CW'(DEPTH);
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  `RSPD_ASSERT(a_no_overflow, push_i |-> !full_o, "push into a full queue")
  `RSPD_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "queue count past depth")

endmodule

// ===== hdl/rspd_drain.sv =====
// Back end: expands each queue entry into one or two result beats.
// Depends on rspd_pkg.
module rspd_drain
  import rspd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  evt_t      head_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t out_item_o
);

  `include "rle_sprite_pixel_decoder_unit_assert.svh"

  logic      sel_second_q, sel_second_d;
  logic      beat;
  out_item_t second;

  assign empty_o = q_empty_i;
  assign beat    = pop_i && !q_empty_i;

  always_comb begin
    second            = '0;
    second.kind       = head_i.second_err ? KIND_ERROR : KIND_DONE;
    second.error_code = head_i.second_err ? ERR_HEADER : ERR_NONE;
    second.last       = 1'b1;
  end

  assign out_item_o = sel_second_q ? second : head_i.first;

  always_comb begin
    sel_second_d = sel_second_q;
    q_pop_o      = 1'b0;
    if (beat) begin
      if (head_i.has_second && !sel_second_q) begin
        sel_second_d = 1'b1;
      end else begin
        sel_second_d = 1'b0;
        q_pop_o      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_second_q <= 1'b0;
    end else begin
      sel_second_q <= sel_second_d;
    end
  end

  `RSPD_ASSERT(a_second_has_entry, sel_second_q |-> !q_empty_i && head_i.has_second, "second beat without entry")

endmodule

// ===== hdl/rle_sprite_pixel_decoder_unit.sv =====
// Run-length sprite decoder: one data byte per cycle in, pixel/done/error results out.
// An accepted byte's results are registered into the result queue and leave at one
// beat per cycle while pop is high; a byte with pixel plus done/error takes two pops.
// Input throughput is one item per cycle while the 4-entry result queue has room.
// Reset clears the parser to idle, empties the queue and loads run_limit with 3076.
// Depends on rspd_pkg, rspd_front, rspd_queue and rspd_drain.
module rle_sprite_pixel_decoder_unit
  import rspd_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT = PIXEL_COUNT_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] run_limit_q;
  logic        accept;
  logic        ev_valid;
  evt_t        ev;
  evt_t        head;
  logic        q_empty;
  logic        q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RUN_LIMIT) ? {16'd0, run_limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_limit_q <= RUN_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RUN_LIMIT) begin
      run_limit_q <= pwdata[15:0];
    end
  end

  assign accept = push && !full;

  rspd_front #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .run_limit_i(run_limit_q),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  rspd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && ev_valid),
    .push_data_i(ev),
    .pop_i      (q_pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (full)
  );

  rspd_drain u_drain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_item_o(out_item_o)
  );

endmodule
